FILE: sv/gcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, microcode table and palette for the glyph cell renderer.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int unsigned GlyphWidth  = 8;
  localparam int unsigned StrideWidth = 13;
  localparam int unsigned AddrWidth   = 24;
  localparam int unsigned PixelWidth  = 24;
  localparam int unsigned StepWidth   = 3;
  localparam logic [StrideWidth-1:0] StrideReset = 13'd1024;
  localparam logic [7:0] MsbPixelMask = 8'h80;
  localparam logic [3:0] NibbleMask   = 4'b1111;

  typedef logic [StepWidth-1:0] step_t;

  // Program step labels
  localparam step_t StepFetch = 3'd0;
  localparam step_t StepWrite = 3'd1;
  localparam step_t StepSetup = 3'd2;
  localparam step_t StepBase  = 3'd3;
  localparam step_t StepEmit  = 3'd4;

  typedef enum logic [1:0] {
    SEQ_NEXT,   // fall through to the next step
    SEQ_GOTO,   // unconditional jump
    SEQ_KIND,   // hold until a request arrives, draw requests jump
    SEQ_LOOP    // hold, jump once the final row has gone out
  } seq_e;

  typedef struct packed {
    logic  wait_in;
    logic  mem_wr;
    logic  setup;
    logic  load_addr;
    logic  emit;
    seq_e  seq;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic kind;
    logic emit_fire;
    logic last;
  } status_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{wait_in: 1'b0, mem_wr: 1'b0, setup: 1'b0, load_addr: 1'b0,
          emit: 1'b0, seq: SEQ_GOTO, target: StepFetch};
    unique case (step)
      StepFetch: begin
        w.wait_in = 1'b1;
        w.seq     = SEQ_KIND;
        w.target  = StepSetup;
      end
      StepWrite: begin
        w.mem_wr = 1'b1;
        w.seq    = SEQ_GOTO;
        w.target = StepFetch;
      end
      StepSetup: begin
        w.setup = 1'b1;
        w.seq   = SEQ_NEXT;
      end
      StepBase: begin
        w.load_addr = 1'b1;
        w.seq       = SEQ_NEXT;
      end
      StepEmit: begin
        w.emit   = 1'b1;
        w.seq    = SEQ_LOOP;
        w.target = StepFetch;
      end
      default: begin
        w.seq    = SEQ_GOTO;
        w.target = StepFetch;
      end
    endcase
    return w;
  endfunction

  function automatic logic [PixelWidth-1:0] palette(input logic [3:0] idx);
    logic [PixelWidth-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'haa0000;
      4'd2:    c = 24'h00aa00;
      4'd3:    c = 24'haa5500;
      4'd4:    c = 24'h0000aa;
      4'd5:    c = 24'haa00aa;
      4'd6:    c = 24'h00aaaa;
      4'd7:    c = 24'haaaaaa;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'hff5555;
      4'd10:   c = 24'h55ff55;
      4'd11:   c = 24'hffff55;
      4'd12:   c = 24'h5555ff;
      4'd13:   c = 24'hff55ff;
      4'd14:   c = 24'h55ffff;
      default: c = 24'hffffff;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/gcr_ucode_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_ucode_seq
// Step counter and microcode ROM; branches on datapath status.
// ----------------------------------------------------------------------------
module gcr_ucode_seq import gcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_t step_q, step_d;
  ctrl_t word;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    step_d = step_q;
    unique case (word.seq)
      SEQ_NEXT: step_d = step_q + step_t'(1);
      SEQ_GOTO: step_d = word.target;
      SEQ_KIND: begin
        if (status_i.in_fire) begin
          step_d = status_i.kind ? word.target : step_q + step_t'(1);
        end
      end
      SEQ_LOOP: begin
        if (status_i.emit_fire && status_i.last) begin
          step_d = word.target;
        end
      end
      default: step_d = StepFetch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepFetch;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: sv/gcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_datapath
// Request registers, font store, address accumulator and output register.
// ----------------------------------------------------------------------------
module gcr_datapath import gcr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT  = 256,
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_t                  ctrl_i,
  output status_t                status_o,
  input  logic [StrideWidth-1:0] stride_i,
  input  logic                   in_valid_i,
  input  logic                   kind_i,
  input  logic [7:0]             code_i,
  input  logic [3:0]             glyph_row_i,
  input  logic [7:0]             font_bits_i,
  input  logic [7:0]             attribute_i,
  input  logic [7:0]             cell_x_i,
  input  logic [7:0]             cell_y_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [AddrWidth-1:0]   row_address_o,
  output logic [PixelWidth-1:0]  pixels_o [GlyphWidth],
  output logic                   last_o
);

  localparam int unsigned Depth = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int unsigned MemAw = $clog2(Depth);
  localparam int unsigned RowW  = $clog2(GLYPH_HEIGHT);
  localparam int unsigned LineW = $clog2(256 * GLYPH_HEIGHT);
  localparam int unsigned ProdW = LineW + StrideWidth;
  localparam logic [RowW-1:0] LastRow = RowW'(GLYPH_HEIGHT - 1);

  logic [7:0] font_mem [Depth];
  logic [7:0] rd_data_q;
  logic [MemAw-1:0] rd_addr, wr_addr;

  logic [7:0] code_q, bits_q, attr_q, cx_q, cy_q;
  logic [3:0] grow_q;
  logic [MemAw-1:0] glyph_base_q;
  logic [LineW-1:0] line0_q;
  logic [PixelWidth-1:0] fg_q, bg_q;
  logic code_ok_q;
  logic [AddrWidth-1:0] addr_q;
  logic [RowW-1:0] row_q, rd_row;
  logic [ProdW-1:0] prod;

  logic out_valid_q;
  logic [AddrWidth-1:0] out_addr_q;
  logic [PixelWidth-1:0] out_pix_q [GlyphWidth];
  logic out_last_q;

  logic in_fire, emit_fire, is_last, wr_ok;
  logic [7:0] row_bits;

  assign in_fire   = ctrl_i.wait_in && in_valid_i;
  assign emit_fire = ctrl_i.emit && (!out_valid_q || !out_stall_i);
  assign is_last   = (row_q == LastRow);
  assign status_o  = '{in_fire: in_fire, kind: kind_i, emit_fire: emit_fire, last: is_last};

  assign wr_ok   = (32'(code_q) < GLYPH_COUNT) && (32'(grow_q) < GLYPH_HEIGHT);
  assign wr_addr = MemAw'(32'(code_q) * GLYPH_HEIGHT) + MemAw'(grow_q);

  // Read address tracks the row that will be current next cycle
  always_comb begin
    rd_row = row_q;
    if (ctrl_i.load_addr) begin
      rd_row = '0;
    end else if (emit_fire && !is_last) begin
      rd_row = row_q + RowW'(1);
    end
  end
  assign rd_addr = glyph_base_q + MemAw'(rd_row);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && wr_ok) begin
      font_mem[wr_addr] <= bits_q;
    end
    rd_data_q <= font_mem[rd_addr];
  end

  assign prod     = ProdW'(line0_q) * ProdW'(stride_i);
  assign row_bits = code_ok_q ? rd_data_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q <= code_i;
      grow_q <= glyph_row_i;
      bits_q <= font_bits_i;
      attr_q <= attribute_i;
      cx_q   <= cell_x_i;
      cy_q   <= cell_y_i;
    end
    if (ctrl_i.setup) begin
      glyph_base_q <= MemAw'(32'(code_q) * GLYPH_HEIGHT);
      line0_q      <= LineW'(32'(cy_q) * GLYPH_HEIGHT);
      fg_q         <= palette(attr_q[3:0] & NibbleMask);
      bg_q         <= palette(attr_q[7:4] & NibbleMask);
      code_ok_q    <= (32'(code_q) < GLYPH_COUNT);
    end
    if (ctrl_i.load_addr) begin
      addr_q <= AddrWidth'(prod) + AddrWidth'({cx_q, 3'b000});
    end else if (emit_fire) begin
      addr_q <= addr_q + AddrWidth'(stride_i);
    end
    if (emit_fire) begin
      out_addr_q <= addr_q;
      out_last_q <= is_last;
      for (int x = 0; x < GlyphWidth; x++) begin
        out_pix_q[x] <= ((row_bits & (MsbPixelMask >> x)) != 8'h00) ? fg_q : bg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load_addr || emit_fire) begin
        row_q <= rd_row;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = out_addr_q;
  assign pixels_o      = out_pix_q;
  assign last_o        = out_last_q;

endmodule

FILE: sv/glyph_cell_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_cell_renderer
// 8-pixel-wide bitmap font renderer: text cell in, pixel rows out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a font
//   write (kind_i = 0) stores font_bits_i as row glyph_row_i of glyph
//   code_i; a draw (kind_i = 1) renders one cell. Writes outside the glyph
//   range are dropped. A draw of a glyph code outside the font is all
//   background. Glyph rows must be written before they are drawn.
//   Output channel (out_valid_o / out_stall_i) returns GLYPH_HEIGHT rows per
//   draw: framebuffer word offset of the row, eight RGB pixels, and last_o
//   on the final row. A font write returns nothing.
//   cfg_we_i / cfg_wdata_i load the line pitch in words (reset 1024); write
//   it only while the block is idle.
// Timing:
//   A microcoded sequencer runs a five-step program. A font write passes
//   through the fetch and write steps. A draw runs the setup steps (request
//   fetch, glyph base and palette lookup, first-row address multiply) and
//   then one row per cycle, while the receiver does not stall, out of
//   the font store's registered read port. The next request is taken
//   as soon as the last row sits in the output register. A stalled
//   receiver holds the output register and the row loop; nothing is
//   dropped. Reset returns the sequencer to the fetch step and empties
//   the output register; the font store keeps no reset.
// ----------------------------------------------------------------------------
module glyph_cell_renderer import gcr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT  = 256,
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [StrideWidth-1:0] cfg_wdata_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [7:0]             code_i,
  input  logic [3:0]             glyph_row_i,
  input  logic [7:0]             font_bits_i,
  input  logic [7:0]             attribute_i,
  input  logic [7:0]             cell_x_i,
  input  logic [7:0]             cell_y_i,
  // row result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [AddrWidth-1:0]   row_address_o,
  output logic [PixelWidth-1:0]  pixel_0_o,
  output logic [PixelWidth-1:0]  pixel_1_o,
  output logic [PixelWidth-1:0]  pixel_2_o,
  output logic [PixelWidth-1:0]  pixel_3_o,
  output logic [PixelWidth-1:0]  pixel_4_o,
  output logic [PixelWidth-1:0]  pixel_5_o,
  output logic [PixelWidth-1:0]  pixel_6_o,
  output logic [PixelWidth-1:0]  pixel_7_o,
  output logic                   last_o
);

  ctrl_t   ctrl;
  status_t status;
  logic [StrideWidth-1:0] stride_q;
  logic [PixelWidth-1:0]  pixels [GlyphWidth];

  // Line pitch register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= StrideReset;
    end else if (cfg_we_i) begin
      stride_q <= cfg_wdata_i;
    end
  end

  // Only the fetch step takes a request
  assign in_stall_o = !ctrl.wait_in;

  gcr_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  gcr_datapath #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .stride_i      (stride_q),
    .in_valid_i    (in_valid_i),
    .kind_i        (kind_i),
    .code_i        (code_i),
    .glyph_row_i   (glyph_row_i),
    .font_bits_i   (font_bits_i),
    .attribute_i   (attribute_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .row_address_o (row_address_o),
    .pixels_o      (pixels),
    .last_o        (last_o)
  );

  assign pixel_0_o = pixels[0];
  assign pixel_1_o = pixels[1];
  assign pixel_2_o = pixels[2];
  assign pixel_3_o = pixels[3];
  assign pixel_4_o = pixels[4];
  assign pixel_5_o = pixels[5];
  assign pixel_6_o = pixels[6];
  assign pixel_7_o = pixels[7];

  // A request moves the program out of the fetch step
  a_fetch_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted twice in a row");

  // No request is taken while a non-final row of a cell is still held
  a_mid_cell_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> in_stall_o)
    else $error("request accepted in the middle of a cell");

  // After the final row leaves, any row that follows opens a new cell
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !(out_valid_o && last_o))
    else $error("row produced after the last row of a cell");

endmodule

FILE: dv/glyph_cell_renderer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_cell_renderer_checker
// Watches the request, row and stride ports of the glyph cell renderer and
// checks every pixel row against its own font copy and palette.
// ----------------------------------------------------------------------------
package gcr_tb_pkg;

  localparam int unsigned GlyphRows = 16;

  typedef enum logic {
    KIND_FONT_WRITE = 1'b0,
    KIND_DRAW       = 1'b1
  } kind_e;

  typedef struct packed {
    logic [23:0]      addr;
    logic [7:0][23:0] px;    // px[0] is the leftmost pixel
    logic             last;
  } row_result_t;

endpackage

module glyph_cell_renderer_checker
  import gcr_pkg::*;
  import gcr_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [StrideWidth-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   kind_i,
  input  logic [7:0]             code_i,
  input  logic [3:0]             glyph_row_i,
  input  logic [7:0]             font_bits_i,
  input  logic [7:0]             attribute_i,
  input  logic [7:0]             cell_x_i,
  input  logic [7:0]             cell_y_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [AddrWidth-1:0]   row_address_i,
  input  logic [PixelWidth-1:0]  pixel_0_i,
  input  logic [PixelWidth-1:0]  pixel_1_i,
  input  logic [PixelWidth-1:0]  pixel_2_i,
  input  logic [PixelWidth-1:0]  pixel_3_i,
  input  logic [PixelWidth-1:0]  pixel_4_i,
  input  logic [PixelWidth-1:0]  pixel_5_i,
  input  logic [PixelWidth-1:0]  pixel_6_i,
  input  logic [PixelWidth-1:0]  pixel_7_i,
  input  logic                   last_i,
  output int                     errors_o,
  output int                     pending_o
);

  localparam logic [PixelWidth-1:0] PaletteRgb [16] = '{
    24'h000000, 24'haa0000, 24'h00aa00, 24'haa5500,
    24'h0000aa, 24'haa00aa, 24'h00aaaa, 24'haaaaaa,
    24'h555555, 24'hff5555, 24'h55ff55, 24'hffff55,
    24'h5555ff, 24'hff55ff, 24'h55ffff, 24'hffffff
  };

  logic [7:0]             font_rows [4096];
  logic [StrideWidth-1:0] stride_q;
  row_result_t            rows_due_q [$];

  // Sixteen rows per cell: foreground where the font bit is set.
  task automatic queue_cell_rows(input logic [7:0] code, input logic [7:0] attr,
                                 input logic [7:0] cx, input logic [7:0] cy);
    row_result_t            res;
    logic [PixelWidth-1:0]  fg;
    logic [PixelWidth-1:0]  bg;
    logic [7:0]             bits;
    logic [31:0]            word_addr;
    fg = PaletteRgb[attr[3:0] & NibbleMask];
    bg = PaletteRgb[attr[7:4] & NibbleMask];
    for (int r = 0; r < GlyphRows; r++) begin
      word_addr = (32'(cy) * GlyphRows + 32'(r)) * 32'(stride_q) + 32'(cx) * GlyphWidth;
      bits      = font_rows[{code, 4'(r)}];
      res.addr  = word_addr[AddrWidth-1:0];
      for (int x = 0; x < GlyphWidth; x++) begin
        res.px[x] = bits[7-x] ? fg : bg;
      end
      res.last = (r == GlyphRows - 1);
      rows_due_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t want;
    row_result_t got;
    logic        bad;
    if (!rst_ni) begin
      rows_due_q.delete();
      stride_q  = StrideReset;
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.addr = row_address_i;
        got.px   = {pixel_7_i, pixel_6_i, pixel_5_i, pixel_4_i,
                    pixel_3_i, pixel_2_i, pixel_1_i, pixel_0_i};
        got.last = last_i;
        if (rows_due_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("unexpected pixel row: addr %06h last %0b", got.addr, got.last);
        end else begin
          want = rows_due_q.pop_front();
          bad  = (got.addr !== want.addr) || (got.last !== want.last);
          for (int x = 0; x < GlyphWidth; x++) begin
            if (got.px[x] !== want.px[x]) bad = 1'b1;
          end
          if (bad) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("row mismatch, expected: addr %06h px %06h %06h %06h %06h %06h %06h %06h %06h last %0b",
                       want.addr, want.px[0], want.px[1], want.px[2], want.px[3],
                       want.px[4], want.px[5], want.px[6], want.px[7], want.last);
              $display("row mismatch, actual:   addr %06h px %06h %06h %06h %06h %06h %06h %06h %06h last %0b",
                       got.addr, got.px[0], got.px[1], got.px[2], got.px[3],
                       got.px[4], got.px[5], got.px[6], got.px[7], got.last);
            end
          end
        end
      end
      if (cfg_we_i) stride_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_FONT_WRITE) font_rows[{code_i, glyph_row_i}] = font_bits_i;
        else queue_cell_rows(code_i, attribute_i, cell_x_i, cell_y_i);
      end
      pending_o = rows_due_q.size();
    end
  end

endmodule

FILE: dv/glyph_cell_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_cell_renderer_tb
// Drives font writes and cell draws into the glyph cell renderer across
// several line pitches and idle/stall mixes; a side checker scores the rows.
// ----------------------------------------------------------------------------
module glyph_cell_renderer_tb;
  import gcr_pkg::*;
  import gcr_tb_pkg::*;

  localparam int unsigned PhaseItems = 76;

  // Directed glyph rows: solid, empty, single edge pixels, alternating bits.
  localparam logic [7:0] EdgeRows [16] = '{
    8'h00, 8'hff, 8'h80, 8'h01, 8'haa, 8'h55, 8'h0f, 8'hf0,
    8'h81, 8'h7e, 8'h18, 8'hc3, 8'h3c, 8'h66, 8'h99, 8'he7
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [StrideWidth-1:0] cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   kind_i;
  logic [7:0]             code_i;
  logic [3:0]             glyph_row_i;
  logic [7:0]             font_bits_i;
  logic [7:0]             attribute_i;
  logic [7:0]             cell_x_i;
  logic [7:0]             cell_y_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [AddrWidth-1:0]   row_address_o;
  logic [PixelWidth-1:0]  pixel_0_o;
  logic [PixelWidth-1:0]  pixel_1_o;
  logic [PixelWidth-1:0]  pixel_2_o;
  logic [PixelWidth-1:0]  pixel_3_o;
  logic [PixelWidth-1:0]  pixel_4_o;
  logic [PixelWidth-1:0]  pixel_5_o;
  logic [PixelWidth-1:0]  pixel_6_o;
  logic [PixelWidth-1:0]  pixel_7_o;
  logic                   last_o;

  int row_errors;
  int rows_pending;

  // Stimulus bookkeeping: which font rows hold data, and which glyphs are
  // complete so they may be drawn (the store is undefined until written).
  logic [15:0] rows_written [256];
  int          ready_codes [$];
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          sent_items;

  glyph_cell_renderer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .code_i       (code_i),
    .glyph_row_i  (glyph_row_i),
    .font_bits_i  (font_bits_i),
    .attribute_i  (attribute_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_address_o(row_address_o),
    .pixel_0_o    (pixel_0_o),
    .pixel_1_o    (pixel_1_o),
    .pixel_2_o    (pixel_2_o),
    .pixel_3_o    (pixel_3_o),
    .pixel_4_o    (pixel_4_o),
    .pixel_5_o    (pixel_5_o),
    .pixel_6_o    (pixel_6_o),
    .pixel_7_o    (pixel_7_o),
    .last_o       (last_o)
  );

  glyph_cell_renderer_checker row_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .code_i       (code_i),
    .glyph_row_i  (glyph_row_i),
    .font_bits_i  (font_bits_i),
    .attribute_i  (attribute_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_address_i(row_address_o),
    .pixel_0_i    (pixel_0_o),
    .pixel_1_i    (pixel_1_o),
    .pixel_2_i    (pixel_2_o),
    .pixel_3_i    (pixel_3_o),
    .pixel_4_i    (pixel_4_o),
    .pixel_5_i    (pixel_5_o),
    .pixel_6_i    (pixel_6_o),
    .pixel_7_i    (pixel_7_o),
    .last_i       (last_o),
    .errors_o     (row_errors),
    .pending_o    (rows_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall decided fresh at every falling edge.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // One request: optional idle gap, then hold valid and payload until taken.
  // Entered and left at a falling edge.
  task automatic send_request(input kind_e kind, input logic [7:0] code,
                              input logic [3:0] grow, input logic [7:0] bits,
                              input logic [7:0] attr, input logic [7:0] cx,
                              input logic [7:0] cy);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    kind_i      = kind;
    code_i      = code;
    glyph_row_i = grow;
    font_bits_i = bits;
    attribute_i = attr;
    cell_x_i    = cx;
    cell_y_i    = cy;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    sent_items++;
  endtask

  // Cell fields are don't-care on a font write; keep them moving anyway.
  task automatic write_font_row(input logic [7:0] code, input logic [3:0] grow,
                                input logic [7:0] bits);
    if (rows_written[code] != 16'hffff) begin
      rows_written[code][grow] = 1'b1;
      if (rows_written[code] == 16'hffff) ready_codes.push_back(int'(code));
    end
    send_request(KIND_FONT_WRITE, code, grow, bits, 8'($urandom),
                 8'($urandom), 8'($urandom));
  endtask

  task automatic draw_cell(input logic [7:0] code, input logic [7:0] attr,
                           input logic [7:0] cx, input logic [7:0] cy);
    send_request(KIND_DRAW, code, 4'($urandom), 8'($urandom), attr, cx, cy);
  endtask

  task automatic fill_glyph(input logic [7:0] code);
    for (int r = 0; r < GlyphRows; r++) begin
      write_font_row(code, 4'(r), 8'($urandom));
    end
  endtask

  task automatic wait_for_rows();
    while (rows_pending != 0) @(negedge clk_i);
  endtask

  // Stride changes only with the block idle; a font write gives no row, so
  // allow a few cycles for one that may still be in the sequencer.
  task automatic set_stride(input logic [StrideWidth-1:0] value);
    wait_for_rows();
    repeat (8) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [StrideWidth-1:0] strides    [5];
    int                     sender_pct [5];
    int                     recv_pct   [5];
    int                     pick;
    int                     phase_start;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_FONT_WRITE;
    code_i      = '0;
    glyph_row_i = '0;
    font_bits_i = '0;
    attribute_i = '0;
    cell_x_i    = '0;
    cell_y_i    = '0;
    sent_items  = 0;
    for (int c = 0; c < 256; c++) rows_written[c] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: one glyph with edge patterns, drawn at the corner cells with
    // the attribute extremes, under the reset pitch.
    for (int r = 0; r < GlyphRows; r++) write_font_row(8'd0, 4'(r), EdgeRows[r]);
    draw_cell(8'd0, 8'h00, 8'd0,   8'd0);
    draw_cell(8'd0, 8'hff, 8'd255, 8'd255);
    draw_cell(8'd0, 8'h0f, 8'd255, 8'd0);
    draw_cell(8'd0, 8'hf0, 8'd0,   8'd255);
    draw_cell(8'd0, 8'h1e, 8'd17,  8'd3);

    // Phases: pitch extremes (including the out-of-range zero and all-ones)
    // paired with the idle/stall mixes.
    strides    = '{13'd8, 13'd4096, 13'($urandom_range(4096, 8)), 13'h1fff, 13'd0};
    sender_pct = '{0, 79, 0, 9, 0};
    recv_pct   = '{0, 0, 79, 9, 0};

    for (int p = 0; p < 5; p++) begin
      set_stride(strides[p]);
      send_idle_pct = sender_pct[p];
      stall_pct     = recv_pct[p];
      phase_start   = sent_items;
      while (sent_items - phase_start < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 7) begin
          // a whole fresh glyph, then it joins the drawable set
          fill_glyph(8'($urandom));
        end else if (pick < 25) begin
          // stray row writes, possibly leaving a glyph half written
          write_font_row(8'($urandom), 4'($urandom), 8'($urandom));
        end else if (pick < 27) begin
          // hold the sender until the output side has caught up
          wait_for_rows();
        end else begin
          draw_cell(8'(ready_codes[$urandom_range(ready_codes.size() - 1)]),
                    8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    wait_for_rows();
    repeat (30) @(negedge clk_i);
    if (row_errors == 0 && rows_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/gcr_pkg.sv
sv/gcr_ucode_seq.sv
sv/gcr_datapath.sv
sv/glyph_cell_renderer.sv
dv/glyph_cell_renderer_checker.sv
dv/glyph_cell_renderer_tb.sv
